// ===== design/lsd_pkg.sv =====
package lsd_pkg;

	// Field widths fixed by the beat formats
	localparam int REQ_TYPE_W   = 1;
	localparam int PROC_IDX_W   = 3;
	localparam int TICKET_W     = 8;
	localparam int RUN_TIME_W   = 16;
	localparam int RND_W        = 31;
	localparam int STATUS_W     = 2;
	localparam int WIN_IDX_W    = 3;
	localparam int WIN_REM_W    = 16;
	localparam int ACTIVE_W     = 4;

	// Defaults for the top level parameters
	localparam int MAX_PROCS_DEF = 8;
	localparam int TIME_BITS_DEF = 16;

	localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 4'd8;

	// Request kinds
	localparam logic [REQ_TYPE_W-1:0] REQ_LOAD = 1'b0;
	localparam logic [REQ_TYPE_W-1:0] REQ_DRAW = 1'b1;

	// Response status codes
	localparam logic [STATUS_W-1:0] STATUS_DONE       = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NO_TICKETS = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_LOADED     = 2'd2;

	typedef struct packed {
		logic [REQ_TYPE_W-1:0] req_type;
		logic [PROC_IDX_W-1:0] proc_index;
		logic [TICKET_W-1:0]   ticket_count;
		logic [RUN_TIME_W-1:0] run_time;
		logic [RND_W-1:0]      random_value;
	} req_beat_t;

	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic [WIN_IDX_W-1:0] winner_index;
		logic [WIN_REM_W-1:0] winner_remaining;
	} rsp_beat_t;

endpackage

// ===== design/lottery_scheduler_draw.sv =====
// Lottery scheduler draw engine.
//
// Request channel (req_valid / req_stall / req): a load beat writes one
// process entry (tickets and run time); a draw beat brings a random value.
// Response channel (rsp_valid / rsp_stall / rsp): exactly one beat per
// request, in request order. cfg_we / cfg_wdata set the number of entries
// that take part in draws (saturated to MAX_PROCS).
//
// One request at a time. A load goes from accept straight to the output
// state. A draw makes one pass over the table RAM to total the tickets
// of the N active entries (one read a cycle), a restoring modulo of the
// 31-bit random value by that total (one quotient bit a cycle on a
// subtract/compare), a second table pass to find the winner, then the
// response register. A zero ticket total skips the modulo and scan. The
// next request can be taken in the same cycle that the response goes
// valid.
//
// Reset clears the entry valid bits (all entries read as zero tickets and
// zero time) and sets the active count to 8. While rsp_stall holds a valid
// response beat, that beat stays put and the engine, once in its output state, waits there.
module lottery_scheduler_draw #(
	parameter int MAX_PROCS = lsd_pkg::MAX_PROCS_DEF,
	parameter int TIME_BITS = lsd_pkg::TIME_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_stall,
	input  lsd_pkg::req_beat_t               req,
	output logic                             rsp_valid,
	input  logic                             rsp_stall,
	output lsd_pkg::rsp_beat_t               rsp,
	input  logic                             cfg_we,
	input  logic [lsd_pkg::ACTIVE_W-1:0]     cfg_wdata
);

	import lsd_pkg::*;

	localparam int AW    = $clog2(MAX_PROCS);          // table address
	localparam int CW    = $clog2(MAX_PROCS + 1);      // entry count
	localparam int TW    = TICKET_W + CW;              // ticket total
	localparam int EW    = TICKET_W + TIME_BITS;       // table entry
	localparam int BIT_W = $clog2(RND_W);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_SUM  = 5'b00010,
		ST_DIV  = 5'b00100,
		ST_SCAN = 5'b01000,
		ST_OUT  = 5'b10000
	} state_t;

	state_t               state_q;
	logic [ACTIVE_W-1:0]  active_q;
	logic [MAX_PROCS-1:0] valid_q;
	logic [CW-1:0]        rd_idx_q;
	logic [TW-1:0]        acc_q;
	logic [BIT_W-1:0]     bit_q;
	logic                 rdv_s1;
	logic                 vld_s1;
	logic [AW-1:0]        idx_s1;
	logic                 rsp_valid_q;

	// payload, no reset
	logic [RND_W-1:0]     rnd_q;
	logic [TW-1:0]        total_q;
	logic [TW-1:0]        rem_q;
	rsp_beat_t            res_q;
	rsp_beat_t            rsp_q;

	logic                 req_fire;
	logic                 load_wr;
	logic [CW-1:0]        n_eff;
	logic                 issue;
	logic [AW-1:0]        raddr;
	logic [EW-1:0]        ram_rdata;
	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [EW-1:0]        ram_wdata;
	logic [TICKET_W-1:0]  tkt_s1;
	logic [TIME_BITS-1:0] tim_s1;
	logic [TIME_BITS-1:0] new_time;
	logic [TW-1:0]        sum_nxt;
	logic                 found;
	logic [TW:0]          div_try;
	logic [TW:0]          div_sub;
	logic                 div_ge;
	logic                 rsp_free;

	assign req_stall = (state_q != ST_IDLE);
	assign req_fire  = req_valid && !req_stall;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;

	// active count saturates at table size
	always_comb begin
		if (32'(active_q) > MAX_PROCS) begin
			n_eff = CW'(MAX_PROCS);
		end else begin
			n_eff = CW'(active_q);
		end
	end

	assign issue = (rd_idx_q < n_eff);
	assign raddr = rd_idx_q[AW-1:0];

	// entries never loaded read as zero
	assign tkt_s1   = vld_s1 ? ram_rdata[EW-1 -: TICKET_W] : '0;
	assign tim_s1   = vld_s1 ? ram_rdata[TIME_BITS-1:0] : '0;
	assign new_time = (tim_s1 == '0) ? '0 : tim_s1 - TIME_BITS'(1);
	assign sum_nxt  = acc_q + TW'(tkt_s1);
	assign found    = rdv_s1 && (rem_q < sum_nxt);

	// restoring modulo step, one dividend bit per cycle
	assign div_try = {rem_q, rnd_q[RND_W-1]};
	assign div_ge  = (div_try >= {1'b0, total_q});
	assign div_sub = div_try - {1'b0, total_q};

	// table write: load beat, or winner write-back at end of scan
	assign load_wr = req_fire && (req.req_type == REQ_LOAD)
		&& (32'(req.proc_index) < MAX_PROCS);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_s1;
		ram_wdata = {tkt_s1, new_time};
		if (load_wr) begin
			ram_we    = 1'b1;
			ram_waddr = AW'(req.proc_index);
			ram_wdata = {req.ticket_count, TIME_BITS'(req.run_time)};
		end else if ((state_q == ST_SCAN) && found) begin
			ram_we = 1'b1;
		end
	end

	lsd_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_PROCS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			active_q    <= ACTIVE_RESET;
			valid_q     <= '0;
			rd_idx_q    <= '0;
			acc_q       <= '0;
			bit_q       <= '0;
			rdv_s1      <= 1'b0;
			vld_s1      <= 1'b0;
			idx_s1      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				active_q <= cfg_wdata;
			end
			if (ram_we) begin
				valid_q[ram_waddr] <= 1'b1;
			end
			// new beat goes out as the old one leaves
			if ((state_q == ST_OUT) && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						rd_idx_q <= '0;
						acc_q    <= '0;
						rdv_s1   <= 1'b0;
						state_q  <= (req.req_type == REQ_LOAD) ? ST_OUT : ST_SUM;
					end
				end
				ST_SUM: begin
					rdv_s1 <= issue;
					vld_s1 <= issue && valid_q[raddr];
					idx_s1 <= raddr;
					if (issue) begin
						rd_idx_q <= rd_idx_q + CW'(1);
					end
					if (rdv_s1) begin
						acc_q <= sum_nxt;
					end
					if (!issue && !rdv_s1) begin
						bit_q   <= BIT_W'(RND_W - 1);
						state_q <= (acc_q == '0) ? ST_OUT : ST_DIV;
					end
				end
				ST_DIV: begin
					if (bit_q == '0) begin
						rd_idx_q <= '0;
						acc_q    <= '0;
						rdv_s1   <= 1'b0;
						state_q  <= ST_SCAN;
					end else begin
						bit_q <= bit_q - BIT_W'(1);
					end
				end
				ST_SCAN: begin
					rdv_s1 <= issue && !found;
					vld_s1 <= issue && valid_q[raddr];
					idx_s1 <= raddr;
					if (issue) begin
						rd_idx_q <= rd_idx_q + CW'(1);
					end
					if (rdv_s1) begin
						acc_q <= sum_nxt;
					end
					if (found || (!issue && !rdv_s1)) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (rsp_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath: modulo, result and response registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				rnd_q <= req.random_value;
				res_q <= '{status: STATUS_LOADED, winner_index: '0, winner_remaining: '0};
			end
			ST_SUM: begin
				total_q <= acc_q;
				rem_q   <= '0;
				res_q   <= '{status: STATUS_NO_TICKETS, winner_index: '0,
					winner_remaining: '0};
			end
			ST_DIV: begin
				rem_q <= div_ge ? div_sub[TW-1:0] : div_try[TW-1:0];
				rnd_q <= rnd_q << 1;
			end
			ST_SCAN: begin
				if (found) begin
					res_q <= '{status: STATUS_DONE, winner_index: WIN_IDX_W'(idx_s1),
						winner_remaining: WIN_REM_W'(new_time)};
				end else begin
					// ran off the end: cannot happen with a nonzero total
					res_q <= '{status: STATUS_DONE,
						winner_index: WIN_IDX_W'(n_eff - CW'(1)), winner_remaining: '0};
				end
			end
			ST_OUT: begin
				if (rsp_free) begin
					rsp_q <= res_q;
				end
			end
			default: begin
				rem_q <= rem_q;
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== design/lsd_ram.sv =====
module lsd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== design/lsd_checker.sv =====
module lsd_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_stall,
	input logic               rsp_valid,
	input logic               rsp_stall,
	input lsd_pkg::rsp_beat_t rsp
);

	import lsd_pkg::*;

	// held response beat stays put
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response beat changed while stalled");

	// one request in flight: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request accepted while previous one in flight");

	// only a finished draw carries a winner
	a_no_winner_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != STATUS_DONE) |->
			(rsp.winner_index == '0) && (rsp.winner_remaining == '0))
		else $error("winner fields set on non-draw response");

endmodule

bind lottery_scheduler_draw lsd_checker u_lsd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_stall(req_stall),
	.rsp_valid(rsp_valid),
	.rsp_stall(rsp_stall),
	.rsp      (rsp)
);
